[hw/rtl/r2h_pkg.sv]
// r2h_pkg: shared widths, payload structs and latency for the RGB to HSV converter.
// Depends on nothing; every other file of the block imports it.
package r2h_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;

  // Width of six times delta, which also bounds the hue dividend.
  localparam int HUE_DW = CHANNEL_BITS + 3;
  // Width of delta * (2^FRACTION_BITS - 1).
  localparam int SAT_NW = CHANNEL_BITS + FRACTION_BITS;

  // One front stage plus one divider cell per quotient bit.
  localparam int LATENCY = FRACTION_BITS + 1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0]  value;
  } hsv_t;

endpackage

[hw/rtl/r2h_front.sv]
// r2h_front: first pipeline stage; finds max, min and sector and forms both dividends.
// Depends on r2h_pkg.
module r2h_front import r2h_pkg::*; (
  input  logic                    clk,
  input  pixel_t                  pixel,
  output logic [CHANNEL_BITS-1:0] value,
  output logic [HUE_DW-1:0]       hue_rem,
  output logic [HUE_DW-1:0]       hue_div,
  output logic [CHANNEL_BITS-1:0] sat_rem,
  output logic [CHANNEL_BITS-1:0] sat_div,
  output logic [FRACTION_BITS-1:0] sat_low
);

  logic [CHANNEL_BITS-1:0] r, g, b, mx, mn, delta;
  logic [HUE_DW-1:0]       r_x, g_x, b_x, d_x, six_d, pos;
  logic [SAT_NW-1:0]       sat_num;
  logic                    grey;

  always_comb begin
    r = pixel.red;
    g = pixel.green;
    b = pixel.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    grey  = (delta == '0);

    r_x   = HUE_DW'(r);
    g_x   = HUE_DW'(g);
    b_x   = HUE_DW'(b);
    d_x   = HUE_DW'(delta);
    six_d = (d_x << 2) + (d_x << 1);

    // Sector choice: red wins ties, then green.
    if (r == mx) begin
      if (g >= b) pos = g_x - b_x;
      else        pos = six_d - (b_x - g_x);
    end else if (g == mx) begin
      pos = (d_x << 1) + b_x - r_x;
    end else begin
      pos = (d_x << 2) + r_x - g_x;
    end

    sat_num = (SAT_NW'(delta) << FRACTION_BITS) - SAT_NW'(delta);
  end

  // A divisor of one with a zero dividend gives a zero quotient, which covers
  // grey and black pixels without separate flags.
  always_ff @(posedge clk) begin
    value   <= mx;
    hue_rem <= grey ? '0 : pos;
    hue_div <= grey ? HUE_DW'(1) : six_d;
    sat_rem <= sat_num[SAT_NW-1:FRACTION_BITS];
    sat_div <= (mx == '0) ? CHANNEL_BITS'(1) : mx;
    sat_low <= sat_num[FRACTION_BITS-1:0];
  end

endmodule

[hw/rtl/r2h_div_cell.sv]
// r2h_div_cell: one restoring-division cell; produces one quotient bit per cycle.
// Depends on r2h_pkg.
module r2h_div_cell import r2h_pkg::*; #(
  parameter int DW = HUE_DW
) (
  input  logic                     clk,
  input  logic [DW-1:0]            rem_in,
  input  logic [DW-1:0]            div_in,
  input  logic [FRACTION_BITS-1:0] low_in,
  input  logic [FRACTION_BITS-1:0] quo_in,
  output logic [DW-1:0]            rem_out,
  output logic [DW-1:0]            div_out,
  output logic [FRACTION_BITS-1:0] low_out,
  output logic [FRACTION_BITS-1:0] quo_out
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        take;

  always_comb begin
    trial = {rem_in, low_in[FRACTION_BITS-1]};
    diff  = trial - {1'b0, div_in};
    take  = (trial >= {1'b0, div_in});
  end

  // The remainder stays below the divisor, so the result fits DW bits.
  always_ff @(posedge clk) begin
    rem_out <= take ? diff[DW-1:0] : trial[DW-1:0];
    div_out <= div_in;
    low_out <= {low_in[FRACTION_BITS-2:0], 1'b0};
    quo_out <= {quo_in[FRACTION_BITS-2:0], take};
  end

endmodule

[hw/rtl/rgb_to_hsv_pixel.sv]
// rgb_to_hsv_pixel: top level of the RGB to HSV pixel converter.
// Depends on r2h_pkg, r2h_front and r2h_div_cell.
//
// The converter takes one pixel per clock and returns its hue, saturation
// and value after the transaction, once taken, has passed through the
// front stage and the divider chain. The pipeline depth is set by the
// two long divisions: each quotient bit is worked out by its own cell of a
// chain of FRACTION_BITS restoring-division cells, after one front stage that
// finds the maximum, minimum and hue sector. Every cell hands its partial
// remainder to the next cell in every cycle, so a new pixel may be offered on
// every clock. busy is high only during reset; outside reset every start is a
// transaction. done marks each result for exactly one cycle and the receiver
// cannot hold it off, so results must be taken as they appear. Grey and black
// pixels give a hue of zero, and black pixels a saturation of zero.
module rgb_to_hsv_pixel import r2h_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  pixel_t pixel,
  output logic   done,
  output hsv_t   result
);

  localparam int NS = FRACTION_BITS;

  logic [HUE_DW-1:0]        hue_rem [NS+1];
  logic [HUE_DW-1:0]        hue_div [NS+1];
  logic [FRACTION_BITS-1:0] hue_low [NS+1];
  logic [FRACTION_BITS-1:0] hue_quo [NS+1];
  logic [CHANNEL_BITS-1:0]  sat_rem [NS+1];
  logic [CHANNEL_BITS-1:0]  sat_div [NS+1];
  logic [FRACTION_BITS-1:0] sat_low [NS+1];
  logic [FRACTION_BITS-1:0] sat_quo [NS+1];
  logic [CHANNEL_BITS-1:0]  value   [NS+1];
  logic [NS:0]              valid;

  assign busy = rst;

  r2h_front u_front (
    .clk     (clk),
    .pixel   (pixel),
    .value   (value[0]),
    .hue_rem (hue_rem[0]),
    .hue_div (hue_div[0]),
    .sat_rem (sat_rem[0]),
    .sat_div (sat_div[0]),
    .sat_low (sat_low[0])
  );

  // The hue dividend is pos shifted up, so its low bits are all zero.
  assign hue_low[0] = '0;
  assign hue_quo[0] = '0;
  assign sat_quo[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    r2h_div_cell #(.DW(HUE_DW)) u_hue (
      .clk     (clk),
      .rem_in  (hue_rem[i]),
      .div_in  (hue_div[i]),
      .low_in  (hue_low[i]),
      .quo_in  (hue_quo[i]),
      .rem_out (hue_rem[i+1]),
      .div_out (hue_div[i+1]),
      .low_out (hue_low[i+1]),
      .quo_out (hue_quo[i+1])
    );

    r2h_div_cell #(.DW(CHANNEL_BITS)) u_sat (
      .clk     (clk),
      .rem_in  (sat_rem[i]),
      .div_in  (sat_div[i]),
      .low_in  (sat_low[i]),
      .quo_in  (sat_quo[i]),
      .rem_out (sat_rem[i+1]),
      .div_out (sat_div[i+1]),
      .low_out (sat_low[i+1]),
      .quo_out (sat_quo[i+1])
    );

    // The value rides alongside the divider cells.
    always_ff @(posedge clk) begin
      value[i+1] <= value[i];
    end
  end

  // Transaction marker follows the data down the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[NS-1:0], start};
    end
  end

  assign done              = valid[NS];
  assign result.hue        = hue_quo[NS];
  assign result.saturation = sat_quo[NS];
  assign result.value      = value[NS];

endmodule

[hw/rtl/r2h_checker.sv]
// r2h_checker: port-level assertions for rgb_to_hsv_pixel, with its bind statement.
// Depends on r2h_pkg and the top level rgb_to_hsv_pixel.
module r2h_checker import r2h_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   start,
  input logic   busy,
  input pixel_t pixel,
  input logic   done,
  input hsv_t   result
);

  // Every accepted transaction gives its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction gave no result");

  // No result appears without a transaction behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result without a transaction");

  // Value is at least as large as every channel of the pixel that was accepted.
  a_value_max: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY
      (result.value >= $past(pixel.red, LATENCY) &&
       result.value >= $past(pixel.green, LATENCY) &&
       result.value >= $past(pixel.blue, LATENCY)))
    else $error("value is not the largest channel");

  // A black pixel has neither hue nor saturation.
  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && result.value == '0) |-> (result.hue == '0 && result.saturation == '0))
    else $error("black pixel with non-zero hue or saturation");

endmodule

bind rgb_to_hsv_pixel r2h_checker u_r2h_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .pixel  (pixel),
  .done   (done),
  .result (result)
);

[verif/rgb_to_hsv_pixel_tb.sv]
`timescale 1ns / 1ps
// rgb_to_hsv_pixel_tb: self-checking testbench for the RGB to HSV pixel converter.
// Depends on r2h_pkg and the rgb_to_hsv_pixel RTL; needs no files or arguments.

module rgb_to_hsv_pixel_tb;
  import r2h_pkg::*;

  localparam real CLK_PERIOD   = 12.0;
  localparam int  RESET_CYCLES = 5;
  localparam int  RANDOM_ITEMS = 500;
  localparam int  MAX_GAP      = 18;
  localparam int  REPORT_LIMIT = 10;
  // Far beyond the slowest legal run: about 520 pixels, each with the longest
  // gap and a full pipeline drain.
  localparam int  LIMIT_CYCLES = 200000;

  // One pixel waiting to be offered, with the idle cycles to insert before it
  // and whether the pipeline must be empty first.
  typedef struct {
    pixel_t      px;
    int unsigned gap;
    bit          drain;
  } pixel_job_t;

  logic   clk   = 1'b0;
  logic   rst   = 1'b1;
  logic   start = 1'b0;
  pixel_t pixel = '0;
  logic   busy;
  logic   done;
  hsv_t   result;

  pixel_job_t pixel_jobs[$];
  hsv_t       hsv_expected[$];

  int total_jobs    = 0;
  int directed_jobs = 0;
  int grey_jobs     = 0;
  int tie_jobs      = 0;
  int drain_jobs    = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int failure_count = 0;
  int idle_cycles   = 0;

  rgb_to_hsv_pixel DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Expected conversion of one pixel. Hue is worked out as the sector offset
  // times delta plus the channel difference, with a negative red-sector hue
  // lifted by a whole turn (six deltas), then scaled to a fraction of a turn
  // and rounded down. Grey and black pixels keep a hue of zero.
  function automatic hsv_t hsv_of(pixel_t px);
    hsv_t                    hsv;
    logic [CHANNEL_BITS-1:0] top;
    logic [CHANNEL_BITS-1:0] bottom;
    logic [63:0]             span;
    logic [63:0]             spoke;
    logic [63:0]             hue_q;
    hsv    = '0;
    top    = px.red;
    bottom = px.red;
    if (px.green > top)    top    = px.green;
    if (px.blue > top)     top    = px.blue;
    if (px.green < bottom) bottom = px.green;
    if (px.blue < bottom)  bottom = px.blue;
    span = 64'(top) - 64'(bottom);
    if (top != '0) begin
      hsv.saturation = FRACTION_BITS'((span * ((64'd1 << FRACTION_BITS) - 64'd1))
                                      / 64'(top));
    end
    if (top != '0 && span != 64'd0) begin
      if (px.red == top) begin
        if (px.green >= px.blue) begin
          spoke = 64'(px.green) - 64'(px.blue);
        end else begin
          spoke = 64'd6 * span - (64'(px.blue) - 64'(px.green));
        end
      end else if (px.green == top) begin
        spoke = 64'd2 * span + 64'(px.blue) - 64'(px.red);
      end else begin
        spoke = 64'd4 * span + 64'(px.red) - 64'(px.green);
      end
      hue_q   = (spoke << FRACTION_BITS) / (64'd6 * span);
      hsv.hue = hue_q[FRACTION_BITS-1:0];
    end
    hsv.value = top;
    return hsv;
  endfunction

  task automatic add_pixel(int r, int g, int b, int unsigned gap, bit drain);
    pixel_job_t job;
    job.px.red   = CHANNEL_BITS'(r);
    job.px.green = CHANNEL_BITS'(g);
    job.px.blue  = CHANNEL_BITS'(b);
    job.gap      = gap;
    job.drain    = drain;
    pixel_jobs.push_back(job);
    total_jobs++;
    if (job.px.red == job.px.green && job.px.green == job.px.blue) grey_jobs++;
    if (drain) drain_jobs++;
  endtask

  task automatic note_failure(string msg);
    if (failure_count < REPORT_LIMIT) $display("%s", msg);
    failure_count++;
  endtask

  // Driver. A transaction happens at each rising edge where start is high and
  // busy is low; its expectation is recorded at that same edge from the pixel
  // that was on the bus. While busy is high an offered pixel is simply held.
  // Only one nonblocking assignment to start is made per edge, so a pixel
  // that follows another with no gap keeps start high without a glitch.
  always @(posedge clk) begin : drive_pixels
    pixel_job_t job;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        hsv_expected.push_back(hsv_of(pixel));
        sent_count++;
      end
      if (start && busy) begin
        // The offered pixel has not been taken yet, so it stays on the bus.
      end else if (pixel_jobs.size() == 0) begin
        start <= 1'b0;
      end else if (pixel_jobs[0].drain && hsv_expected.size() != 0) begin
        // Hold off until every pixel in flight has produced its result.
        start <= 1'b0;
      end else if (idle_cycles < int'(pixel_jobs[0].gap)) begin
        idle_cycles++;
        start <= 1'b0;
      end else begin
        job         = pixel_jobs.pop_front();
        idle_cycles = 0;
        start <= 1'b1;
        pixel <= job.px;
      end
    end
  end

  // Monitor. The receiver cannot stall the block, so every cycle with done
  // high is one result transaction, checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    hsv_t want;
    if (!rst && done) begin
      if (hsv_expected.size() == 0) begin
        note_failure($sformatf("unexpected result at %0t: hue %0d sat %0d val %0d",
                               $realtime, result.hue, result.saturation, result.value));
      end else begin
        want = hsv_expected.pop_front();
        checked_count++;
        if (result.hue !== want.hue || result.saturation !== want.saturation ||
            result.value !== want.value) begin
          note_failure($sformatf({"mismatch at %0t: expected hue %0d sat %0d val %0d,",
                                  " got hue %0d sat %0d val %0d"},
                                 $realtime, want.hue, want.saturation, want.value,
                                 result.hue, result.saturation, result.value));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int burst_mode;
    int unsigned gap;
    int r, g, b, base, peak, low, pick;

    // Directed pixels: black, white and grey, the primaries and secondaries
    // (ties between channels for the maximum), the red sector on both sides
    // of zero hue so that the wrap is exercised, and the smallest non-zero
    // channel values.
    add_pixel(0,   0,   0,   0, 1'b0);
    add_pixel(255, 255, 255, 0, 1'b0);
    add_pixel(128, 128, 128, 3, 1'b0);
    add_pixel(1,   1,   1,   0, 1'b0);
    add_pixel(255, 0,   0,   0, 1'b0);
    add_pixel(0,   255, 0,   0, 1'b0);
    add_pixel(0,   0,   255, 5, 1'b0);
    add_pixel(255, 255, 0,   0, 1'b0);
    add_pixel(0,   255, 255, 0, 1'b0);
    add_pixel(255, 0,   255, 0, 1'b0);
    add_pixel(255, 0,   1,   1, 1'b0);
    add_pixel(255, 1,   0,   0, 1'b0);
    add_pixel(1,   0,   0,   0, 1'b0);
    add_pixel(0,   1,   0,   MAX_GAP, 1'b0);
    add_pixel(0,   0,   1,   0, 1'b0);
    add_pixel(255, 255, 254, 0, 1'b0);
    add_pixel(254, 255, 255, 2, 1'b0);
    add_pixel(255, 254, 255, 0, 1'b0);
    add_pixel(1,   1,   0,   0, 1'b0);
    add_pixel(128, 0,   255, 0, 1'b0);
    add_pixel(170, 85,  0,   0, 1'b0);
    tie_jobs      = 7;
    directed_jobs = total_jobs;

    // Random pixels, in bursts that each keep one idling style, so that some
    // stretches run back to back while others are sparse.
    burst_mode = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) burst_mode = $urandom_range(0, 2);
      case (burst_mode)
        0: gap = 0;
        1: gap = $urandom_range(0, MAX_GAP);
        default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      endcase
      case ($urandom_range(0, 9))
        5: begin
          // Nearly grey: tiny delta gives the coarsest hue divisions.
          base = $urandom_range(2, 253);
          r = base + int'($urandom_range(0, 4)) - 2;
          g = base + int'($urandom_range(0, 4)) - 2;
          b = base + int'($urandom_range(0, 4)) - 2;
        end
        6: begin
          // Two or three channels tie for the maximum.
          peak = $urandom_range(0, 255);
          low  = $urandom_range(0, peak);
          pick = $urandom_range(0, 3);
          r = (pick == 2) ? low : peak;
          g = (pick == 1) ? low : peak;
          b = (pick == 0) ? low : peak;
          tie_jobs++;
        end
        7: begin
          r = ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1);
          g = ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1);
          b = ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1);
        end
        8: begin
          r = $urandom_range(0, 255);
          g = $urandom_range(0, 255);
          b = 0;
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            b = r;
            r = 0;
          end else if (pick == 1) begin
            b = g;
            g = 0;
          end
        end
        9: begin
          r = $urandom_range(0, 255);
          g = r;
          b = r;
        end
        default: begin
          r = $urandom_range(0, 255);
          g = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
      endcase
      // The first random pixel, one in the middle and a few others wait for
      // the pipeline to empty completely before they are offered.
      add_pixel(r, g, b, gap,
                (i == 0 || i == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_jobs) @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
    // Allow for any stray result still in the pipeline.
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d pixels (%0d directed, %0d grey or black, %0d with tied maxima)",
             sent_count, directed_jobs, grey_jobs, tie_jobs);
    $display("%0d results checked, %0d drain pauses, %0d failures",
             checked_count, drain_jobs, failure_count);
    if (failure_count == 0 && hsv_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hang: a missing result or a stuck busy ends up here.
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", hsv_expected.size());
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/r2h_pkg.sv
hw/rtl/r2h_front.sv
hw/rtl/r2h_div_cell.sv
hw/rtl/rgb_to_hsv_pixel.sv
hw/rtl/r2h_checker.sv
verif/rgb_to_hsv_pixel_tb.sv
